// ===== hw/rtl/p2kb_pkg.sv =====
// shared widths, register codes and kernel weight table for the blur core
`default_nettype none

package p2kb_pkg;

  // field widths
  localparam int PIX_W   = 16;
  localparam int COORD_W = 8;
  localparam int SIZE_W  = 9;
  localparam int KSIZE_W = 4;
  localparam int HALF_W  = 3;
  localparam int TAP_W   = 4;

  // accumulator and divider widths: 65535 * 145924 fits in 34 bits
  localparam int ACC_W = 34;
  localparam int TOT_W = 18;
  localparam int QUO_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE = 4'd1;

  localparam logic [SIZE_W-1:0]  IMAGE_SIZE_RST  = 9'd256;
  localparam logic [KSIZE_W-1:0] KERNEL_SIZE_RST = 4'd5;

  // total kernel weight (3*2^h-2)^2 for half width h
  function automatic logic [TOT_W-1:0] kernel_total(logic [HALF_W-1:0] half);
    logic [TOT_W-1:0] tot;
    case (half)
      3'd0:    tot = 18'd1;
      3'd1:    tot = 18'd16;
      3'd2:    tot = 18'd100;
      3'd3:    tot = 18'd484;
      3'd4:    tot = 18'd2116;
      3'd5:    tot = 18'd8836;
      3'd6:    tot = 18'd36100;
      default: tot = 18'd145924;
    endcase
    return tot;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/p2kb_if.sv =====
// valid/ready channel interfaces for requests, results and configuration
`default_nettype none

interface p2kb_req_if
  import p2kb_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [PIX_W-1:0]   pixel;

  modport source (output valid, req_type, row, col, pixel, input ready);
  modport sink   (input valid, req_type, row, col, pixel, output ready);
endinterface

interface p2kb_res_if
  import p2kb_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   filtered_value;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;

  modport source (output valid, filtered_value, out_row, out_col, input ready);
  modport sink   (input valid, filtered_value, out_row, out_col, output ready);
endinterface

interface p2kb_cfg_if
  import p2kb_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/p2kb_frame.sv =====
// frame memory: one write port, one read port with registered read data
`default_nettype none

module p2kb_frame
  import p2kb_pkg::*;
#(
  parameter int CW = 8
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [2*CW-1:0]   waddr_i,
  input  wire logic [PIX_W-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [2*CW-1:0]   raddr_i,
  output logic      [PIX_W-1:0]  rdata_o
);

  logic [PIX_W-1:0] mem [2**(2*CW)];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/p2kb_div.sv =====
// restoring divider: 16 quotient bits, one compare and subtract per cycle
`default_nettype none

module p2kb_div
  import p2kb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ACC_W-1:0]  dividend_i,
  input  wire logic [TOT_W-1:0]  divisor_i,
  output logic                   busy_o,
  output logic      [QUO_W-1:0]  quotient_o
);

  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0] rem_q, rem_d;
  logic [ACC_W-1:0] dsr_q, dsr_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic             ge;

  // one quotient bit per cycle, shifted divisor walks right
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    ge     = (rem_q >= dsr_q);
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i;
      dsr_d  = ACC_W'({divisor_i, {(QUO_W-1){1'b0}}});
      quo_d  = '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsr_q;
      end
      quo_d = {quo_q[QUO_W-2:0], ge};
      dsr_d = dsr_q >> 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      quo_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      dsr_q  <= dsr_d;
      quo_q  <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pow2_kernel_blur_clamped_core.sv =====
// Blur core: a load transaction writes one pixel into the frame memory. A filter
// transaction for an odd kernel side k does one frame memory read per window tap,
// then runs the serial divider; an even kernel reads only the centre pixel. The
// next transaction is accepted once the sequencer is idle again.
// Reset: image_size 256, kernel_size 5, no result pending; frame memory undefined.
`default_nettype none

module pow2_kernel_blur_clamped_core
  import p2kb_pkg::*;
#(
  parameter int MAX_SIZE   = 256,
  parameter int MAX_KERNEL = 15
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  p2kb_req_if.sink   req_i,
  p2kb_res_if.source res_o,
  p2kb_cfg_if.sink   cfg_i
);

  localparam int CW = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1;
  localparam logic [SIZE_W-1:0]  SIDE_CAP = SIZE_W'((MAX_SIZE > 511) ? 511 : MAX_SIZE);
  localparam logic [KSIZE_W-1:0] KCAP     = KSIZE_W'((MAX_KERNEL > 15) ? 15 : MAX_KERNEL);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FLUSH,
    S_START,
    S_DIV
  } state_e;

  // clamp a window position to the frame
  function automatic logic [SIZE_W-1:0] edge_pos(logic [COORD_W-1:0] centre,
                                                 logic [TAP_W-1:0] d,
                                                 logic [HALF_W-1:0] half,
                                                 logic [SIZE_W-1:0] side);
    logic signed [SIZE_W:0] pos;
    logic [SIZE_W-1:0]      res;
    pos = $signed({2'b00, centre}) + $signed({6'b0, d}) - $signed({7'b0, half});
    if (pos < 0) begin
      res = '0;
    end else if (pos[SIZE_W-1:0] >= side) begin
      res = side - SIZE_W'(1);
    end else begin
      res = pos[SIZE_W-1:0];
    end
    return res;
  endfunction

  // weight exponent of tap d: min(d, 2h - d)
  function automatic logic [TAP_W-1:0] tap_exp(logic [TAP_W-1:0] d, logic [HALF_W-1:0] half);
    logic [TAP_W-1:0] two_h;
    two_h = {half, 1'b0};
    return (d <= TAP_W'(half)) ? d : (two_h - d);
  endfunction

  state_e state_q, state_d;

  logic [SIZE_W-1:0]  image_size_q, image_size_d;
  logic [KSIZE_W-1:0] kernel_size_q, kernel_size_d;

  logic [COORD_W-1:0] row_q, row_d;
  logic [COORD_W-1:0] col_q, col_d;
  logic [SIZE_W-1:0]  side_q, side_d;
  logic [HALF_W-1:0]  half_q, half_d;
  logic [TAP_W-1:0]   dr_q, dr_d;
  logic [TAP_W-1:0]   dc_q, dc_d;
  logic               v_q, v_d;
  logic [TAP_W:0]     exp_q, exp_d;
  logic [ACC_W-1:0]   acc_q, acc_d;

  logic               res_valid_q, res_valid_d;
  logic [PIX_W-1:0]   res_value_q, res_value_d;
  logic [COORD_W-1:0] res_row_q, res_row_d;
  logic [COORD_W-1:0] res_col_q, res_col_d;

  logic [SIZE_W-1:0]  side;
  logic [SIZE_W-1:0]  side_m1;
  logic [COORD_W-1:0] req_row_c;
  logic [COORD_W-1:0] req_col_c;
  logic [KSIZE_W-1:0] k_eff;
  logic [HALF_W-1:0]  half_new;
  logic               req_acc;
  logic               last_tap;
  logic [TAP_W-1:0]   two_h;
  logic [SIZE_W-1:0]  pr;
  logic [SIZE_W-1:0]  pc;

  logic              mem_we;
  logic [2*CW-1:0]   mem_waddr;
  logic              mem_re;
  logic [2*CW-1:0]   mem_raddr;
  logic [PIX_W-1:0]  mem_rdata;

  logic              div_start;
  logic              div_busy;
  logic [QUO_W-1:0]  div_quo;

  // effective frame side and clamped request coordinates
  always_comb begin
    if (image_size_q < SIZE_W'(2)) begin
      side = SIZE_W'(2);
    end else if (image_size_q > SIDE_CAP) begin
      side = SIDE_CAP;
    end else begin
      side = image_size_q;
    end
    side_m1   = side - SIZE_W'(1);
    req_row_c = ({1'b0, req_i.row} >= side) ? side_m1[COORD_W-1:0] : req_i.row;
    req_col_c = ({1'b0, req_i.col} >= side) ? side_m1[COORD_W-1:0] : req_i.col;
    k_eff     = (kernel_size_q > KCAP) ? KCAP : kernel_size_q;
    half_new  = k_eff[0] ? k_eff[KSIZE_W-1:1] : '0;
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // frame write on a load transaction
  assign mem_we    = req_acc && !req_i.req_type;
  assign mem_waddr = {CW'(req_row_c), CW'(req_col_c)};

  // window read address
  assign two_h     = {half_q, 1'b0};
  assign last_tap  = (dr_q == two_h) && (dc_q == two_h);
  assign pr        = edge_pos(row_q, dr_q, half_q, side_q);
  assign pc        = edge_pos(col_q, dc_q, half_q, side_q);
  assign mem_re    = (state_q == S_READ);
  assign mem_raddr = {CW'(pr), CW'(pc)};

  assign div_start = (state_q == S_START);

  // sequencer, window walk, accumulator, result register, config registers
  always_comb begin
    state_d       = state_q;
    image_size_d  = image_size_q;
    kernel_size_d = kernel_size_q;
    row_d         = row_q;
    col_d         = col_q;
    side_d        = side_q;
    half_d        = half_q;
    dr_d          = dr_q;
    dc_d          = dc_q;
    v_d           = 1'b0;
    exp_d         = exp_q;
    acc_d         = acc_q;
    res_valid_d   = res_valid_q;
    res_value_d   = res_value_q;
    res_row_d     = res_row_q;
    res_col_d     = res_col_q;

    // config writes
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_IMAGE_SIZE:  image_size_d  = cfg_i.data;
        CFG_KERNEL_SIZE: kernel_size_d = cfg_i.data[KSIZE_W-1:0];
        default: ;
      endcase
    end

    // result register drains independently
    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end

    // accumulate the pixel read in the previous cycle
    if (v_q) begin
      acc_d = acc_q + (ACC_W'(mem_rdata) << exp_q);
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_acc && req_i.req_type) begin
          row_d   = req_row_c;
          col_d   = req_col_c;
          side_d  = side;
          half_d  = half_new;
          dr_d    = '0;
          dc_d    = '0;
          acc_d   = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        v_d   = 1'b1;
        exp_d = {1'b0, tap_exp(dr_q, half_q)} + {1'b0, tap_exp(dc_q, half_q)};
        if (dc_q == two_h) begin
          dc_d = '0;
          dr_d = dr_q + TAP_W'(1);
        end else begin
          dc_d = dc_q + TAP_W'(1);
        end
        if (last_tap) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_d = S_START;
      end
      S_START: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (!div_busy && (!res_valid_q || res_o.ready)) begin
          res_valid_d = 1'b1;
          res_value_d = div_quo;
          res_row_d   = row_q;
          res_col_d   = col_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      image_size_q  <= IMAGE_SIZE_RST;
      kernel_size_q <= KERNEL_SIZE_RST;
      row_q         <= '0;
      col_q         <= '0;
      side_q        <= '0;
      half_q        <= '0;
      dr_q          <= '0;
      dc_q          <= '0;
      v_q           <= 1'b0;
      exp_q         <= '0;
      acc_q         <= '0;
      res_valid_q   <= 1'b0;
      res_value_q   <= '0;
      res_row_q     <= '0;
      res_col_q     <= '0;
    end else begin
      state_q       <= state_d;
      image_size_q  <= image_size_d;
      kernel_size_q <= kernel_size_d;
      row_q         <= row_d;
      col_q         <= col_d;
      side_q        <= side_d;
      half_q        <= half_d;
      dr_q          <= dr_d;
      dc_q          <= dc_d;
      v_q           <= v_d;
      exp_q         <= exp_d;
      acc_q         <= acc_d;
      res_valid_q   <= res_valid_d;
      res_value_q   <= res_value_d;
      res_row_q     <= res_row_d;
      res_col_q     <= res_col_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.filtered_value = res_value_q;
  assign res_o.out_row        = res_row_q;
  assign res_o.out_col        = res_col_q;

  // frame memory
  p2kb_frame #(
    .CW (CW)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (req_i.pixel),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // divide by total kernel weight
  p2kb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (kernel_total(half_q)),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

endmodule

`default_nettype wire
